// ===== design/msod_pkg.sv =====
// ----------------------------------------------------------------------------
// msod_pkg
// Shared types and codes of the multi-sensor obstacle debouncer.
// ----------------------------------------------------------------------------
package msod_pkg;

	localparam int IDX_W  = 3;   // sensor index field
	localparam int DIST_W = 13;  // distance in 1/16 cm
	localparam int RUN_W  = 4;   // debounce run counter
	localparam int LIM_W  = 5;   // sensor limit, holds up to 31
	localparam int THR_W  = 9;   // threshold in cm
	localparam int CFG_W  = 9;   // config write data
	localparam int CFGI_W = 2;   // config register index

	// input opcodes
	localparam logic [2:0] OPC_SAMPLE = 3'd0;
	localparam logic [2:0] OPC_START  = 3'd1;
	localparam logic [2:0] OPC_STOP   = 3'd2;
	localparam logic [2:0] OPC_CLEAR  = 3'd3;
	localparam logic [2:0] OPC_RSTAT  = 3'd4;

	// measurement status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;

	// result event kinds
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_DETECT = 2'd1;
	localparam logic [1:0] EV_CLEAR  = 2'd2;

	// run modes as reported
	localparam logic [1:0] MODE_STOPPED  = 2'd0;
	localparam logic [1:0] MODE_RUNNING  = 2'd1;
	localparam logic [1:0] MODE_OBSTACLE = 2'd2;

	// config register indexes
	localparam logic [CFGI_W-1:0] CFG_ACTIVE   = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_THRESH   = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_DEBOUNCE = 2'd2;

	localparam logic [RUN_W-1:0]  RUN_SAT  = 4'd15;
	localparam logic [DIST_W-1:0] DIST_MAX = 13'd8191;

	// classified commands
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_SAMPLE,
		CMD_START,
		CMD_STOP,
		CMD_CLEAR,
		CMD_RSTAT
	} cmd_t;

	// one classified beat, front to back
	typedef struct packed {
		cmd_t              op;
		logic              upd;      // status ok or timeout: sensor gets updated
		logic              close;    // closer than the threshold
		logic              last;     // round end
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dist_q4;  // timeout already replaced
	} item_t;

endpackage

// ===== design/msod_front.sv =====
// ----------------------------------------------------------------------------
// msod_front
// Decodes an input beat and classifies the sample against the threshold.
// ----------------------------------------------------------------------------
module msod_front (
	input  logic [2:0]                   opcode,
	input  logic [msod_pkg::IDX_W-1:0]   sensor_index,
	input  logic [1:0]                   measure_status,
	input  logic [msod_pkg::DIST_W-1:0]  distance_q4,
	input  logic                         last_in_round,
	input  logic [msod_pkg::LIM_W-1:0]   limit,
	input  logic [msod_pkg::THR_W-1:0]   threshold_cm,
	output msod_pkg::item_t              item
);

	logic [msod_pkg::DIST_W-1:0] thr_q4;
	logic [msod_pkg::THR_W:0]    thr_p1;
	logic [msod_pkg::DIST_W:0]   tmo_q4;
	logic [msod_pkg::DIST_W-1:0] tmo_sat;
	logic                        in_range;

	always_comb begin
		thr_q4   = {threshold_cm, 4'b0000};
		thr_p1   = {1'b0, threshold_cm} + 10'd1;
		tmo_q4   = {thr_p1, 4'b0000};
		tmo_sat  = tmo_q4[msod_pkg::DIST_W] ? msod_pkg::DIST_MAX : tmo_q4[msod_pkg::DIST_W-1:0];
		in_range = {2'b00, sensor_index} < limit;

		item.upd     = (measure_status == msod_pkg::ST_OK) ||
		               (measure_status == msod_pkg::ST_TIMEOUT);
		item.close   = (measure_status == msod_pkg::ST_OK) && (distance_q4 < thr_q4);
		item.last    = last_in_round;
		item.idx     = sensor_index;
		item.dist_q4 = (measure_status == msod_pkg::ST_TIMEOUT) ? tmo_sat : distance_q4;

		case (opcode)
			msod_pkg::OPC_SAMPLE: item.op = in_range ? msod_pkg::CMD_SAMPLE : msod_pkg::CMD_NOP;
			msod_pkg::OPC_START:  item.op = msod_pkg::CMD_START;
			msod_pkg::OPC_STOP:   item.op = msod_pkg::CMD_STOP;
			msod_pkg::OPC_CLEAR:  item.op = msod_pkg::CMD_CLEAR;
			msod_pkg::OPC_RSTAT:  item.op = msod_pkg::CMD_RSTAT;
			default:              item.op = msod_pkg::CMD_NOP;
		endcase
	end

endmodule

// ===== design/msod_queue.sv =====
// ----------------------------------------------------------------------------
// msod_queue
// Two-entry queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module msod_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  msod_pkg::item_t push_item,
	input  logic            pop,
	output msod_pkg::item_t pop_item,
	output logic            full,
	output logic            empty
);

	msod_pkg::item_t mem_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/msod_back.sv =====
// ----------------------------------------------------------------------------
// msod_back
// Applies classified beats to the sensor and mode state; result register.
// ----------------------------------------------------------------------------
module msod_back #(
	parameter int MAX_SENSORS = 8,
	parameter int STAT_WIDTH  = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  msod_pkg::item_t             cmd,
	output logic                        pop,
	input  logic [msod_pkg::LIM_W-1:0]  limit,
	input  logic [msod_pkg::RUN_W-1:0]  debounce_needed,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  event_kind,
	output logic [msod_pkg::IDX_W-1:0]  event_sensor,
	output logic [msod_pkg::DIST_W-1:0] event_distance_q4,
	output logic                        stop_motors,
	output logic [1:0]                  run_mode,
	output logic [STAT_WIDTH-1:0]       poll_count,
	output logic [STAT_WIDTH-1:0]       obstacle_count,
	output logic [STAT_WIDTH-1:0]       false_positive_total
);

	logic [msod_pkg::RUN_W-1:0] run_q [MAX_SENSORS];
	logic [MAX_SENSORS-1:0]     act_q;
	logic [1:0]                 mode_q;
	logic [STAT_WIDTH-1:0]      polls_q, det_q, fp_q;
	logic                       out_valid_q;

	logic [MAX_SENSORS-1:0]     sel, mask, act_nx;
	logic [msod_pkg::RUN_W-1:0] run_old, run_inc, run_new;
	logic                       act_old, go, detect, clr_ev, fp_hit, any;
	logic [1:0]                 mode_nx, kind_nx;
	logic                       stop_nx;
	logic [STAT_WIDTH-1:0]      polls_nx, det_nx, fp_nx;

	assign pop       = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		run_old = '0;
		act_old = 1'b0;
		for (int i = 0; i < MAX_SENSORS; i++) begin
			sel[i]  = {1'b0, cmd.idx} == 4'(i);
			mask[i] = 5'(i) < limit;
			if (sel[i]) begin
				run_old = run_q[i];
				act_old = act_q[i];
			end
		end
		run_inc = (run_old == msod_pkg::RUN_SAT) ? run_old : run_old + 4'd1;
		go      = cmd.op == msod_pkg::CMD_SAMPLE && mode_q != msod_pkg::MODE_STOPPED;

		detect = 1'b0;
		clr_ev = 1'b0;
		fp_hit = 1'b0;
		if (cmd.close) begin
			run_new = run_inc;
			detect  = go && cmd.upd && run_inc >= debounce_needed && !act_old;
		end else begin
			run_new = '0;
			fp_hit  = go && cmd.upd && run_old != '0 && run_old < debounce_needed;
			clr_ev  = go && cmd.upd && act_old;
		end

		for (int i = 0; i < MAX_SENSORS; i++) begin
			act_nx[i] = act_q[i];
			if (sel[i] && detect) begin
				act_nx[i] = 1'b1;
			end else if (sel[i] && clr_ev) begin
				act_nx[i] = 1'b0;
			end
		end
		any = |(act_nx & mask);

		mode_nx = mode_q;
		stop_nx = 1'b0;
		case (cmd.op)
			msod_pkg::CMD_SAMPLE: begin
				if (go && cmd.last) begin
					if (any && mode_q != msod_pkg::MODE_OBSTACLE) begin
						mode_nx = msod_pkg::MODE_OBSTACLE;
						stop_nx = 1'b1;
					end else if (!any && mode_q == msod_pkg::MODE_OBSTACLE) begin
						mode_nx = msod_pkg::MODE_RUNNING;
					end
				end
			end
			msod_pkg::CMD_START: begin
				if (mode_q == msod_pkg::MODE_STOPPED) begin
					mode_nx = msod_pkg::MODE_RUNNING;
				end
			end
			msod_pkg::CMD_STOP:  mode_nx = msod_pkg::MODE_STOPPED;
			msod_pkg::CMD_CLEAR: begin
				if (mode_q == msod_pkg::MODE_OBSTACLE) begin
					mode_nx = msod_pkg::MODE_RUNNING;
				end
			end
			default: mode_nx = mode_q;
		endcase

		if (cmd.op == msod_pkg::CMD_RSTAT) begin
			polls_nx = '0;
			det_nx   = '0;
			fp_nx    = '0;
		end else begin
			polls_nx = polls_q + STAT_WIDTH'(go && cmd.last);
			det_nx   = det_q + STAT_WIDTH'(detect);
			fp_nx    = fp_q + STAT_WIDTH'(fp_hit);
		end

		kind_nx = detect ? msod_pkg::EV_DETECT : (clr_ev ? msod_pkg::EV_CLEAR : msod_pkg::EV_NONE);
	end

	// sensor, mode and statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SENSORS; i++) begin
				run_q[i] <= '0;
			end
			act_q       <= '0;
			mode_q      <= msod_pkg::MODE_STOPPED;
			polls_q     <= '0;
			det_q       <= '0;
			fp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				for (int i = 0; i < MAX_SENSORS; i++) begin
					if (cmd.op == msod_pkg::CMD_CLEAR && mask[i]) begin
						run_q[i] <= '0;
						act_q[i] <= 1'b0;
					end else if (sel[i] && go && cmd.upd) begin
						run_q[i] <= run_new;
						act_q[i] <= act_nx[i];
					end
				end
				mode_q  <= mode_nx;
				polls_q <= polls_nx;
				det_q   <= det_nx;
				fp_q    <= fp_nx;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			event_kind           <= kind_nx;
			event_sensor         <= (kind_nx != msod_pkg::EV_NONE) ? cmd.idx : '0;
			event_distance_q4    <= (kind_nx != msod_pkg::EV_NONE) ? cmd.dist_q4 : '0;
			stop_motors          <= stop_nx;
			run_mode             <= mode_nx;
			poll_count           <= polls_nx;
			obstacle_count       <= det_nx;
			false_positive_total <= fp_nx;
		end
	end

endmodule

// ===== design/multi_sensor_obstacle_debouncer.sv =====
// ----------------------------------------------------------------------------
// multi_sensor_obstacle_debouncer
// Per-sensor debounced obstacle detection with run mode and statistics.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): one beat is a ranging sample or a
//    start/stop/clear/reset-stats command. Every beat gives one result beat.
//  - Output channel (out_valid/out_stall): event edge, stop_motors pulse,
//    run mode and the three statistics counters as they stand after the beat.
//  - Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0
//    active sensors, 1 threshold in cm, 2 debounce count. Write when idle.
//  - Path: an accepted beat goes into the queue, then into the result register.
//  - Throughput: one beat per cycle while the receiver does not stall. The front
//    decodes and compares the distance combinationally into a two-entry queue;
//    the back updates the sensor state and loads the result register together.
//  - Stall: when the receiver stalls, the result register holds, the back
//    stops draining, and in_stall rises once both queue entries are filled.
//  - Reset: queue empty, all sensors idle, mode stopped, counters zero,
//    config back to 1 sensor, 30 cm, 3 samples.
// ----------------------------------------------------------------------------
module multi_sensor_obstacle_debouncer #(
	parameter int MAX_SENSORS = 8,
	parameter int STAT_WIDTH  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample / command beats
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic [msod_pkg::IDX_W-1:0]    sensor_index,
	input  logic [1:0]                    measure_status,
	input  logic [msod_pkg::DIST_W-1:0]   distance_q4,
	input  logic                          last_in_round,
	// result beats
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    event_kind,
	output logic [msod_pkg::IDX_W-1:0]    event_sensor,
	output logic [msod_pkg::DIST_W-1:0]   event_distance_q4,
	output logic                          stop_motors,
	output logic [1:0]                    run_mode,
	output logic [STAT_WIDTH-1:0]         poll_count,
	output logic [STAT_WIDTH-1:0]         obstacle_count,
	output logic [STAT_WIDTH-1:0]         false_positive_total,
	// config writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msod_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [msod_pkg::CFG_W-1:0]    cfg_data
);

	logic [3:0]                 active_sensors_q;
	logic [msod_pkg::THR_W-1:0] threshold_cm_q;
	logic [msod_pkg::RUN_W-1:0] debounce_needed_q;
	logic [msod_pkg::LIM_W-1:0] limit;

	msod_pkg::item_t front_item, back_item;
	logic            q_full, q_empty, q_pop, q_push;

	assign cfg_ready = 1'b1;

	// config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_sensors_q  <= 4'd1;
			threshold_cm_q    <= 9'd30;
			debounce_needed_q <= 4'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				msod_pkg::CFG_ACTIVE:   active_sensors_q  <= cfg_data[3:0];
				msod_pkg::CFG_THRESH:   threshold_cm_q    <= cfg_data;
				msod_pkg::CFG_DEBOUNCE: debounce_needed_q <= cfg_data[3:0];
				default:                ;
			endcase
		end
	end

	// polled sensor count: zero acts as one, clamp to the sensors built
	always_comb begin
		if (active_sensors_q == 4'd0) begin
			limit = 5'd1;
		end else if ({1'b0, active_sensors_q} > 5'(MAX_SENSORS)) begin
			limit = 5'(MAX_SENSORS);
		end else begin
			limit = {1'b0, active_sensors_q};
		end
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !in_stall;

	msod_front u_front (
		.opcode         (opcode),
		.sensor_index   (sensor_index),
		.measure_status (measure_status),
		.distance_q4    (distance_q4),
		.last_in_round  (last_in_round),
		.limit          (limit),
		.threshold_cm   (threshold_cm_q),
		.item           (front_item)
	);

	msod_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.pop       (q_pop),
		.pop_item  (back_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	msod_back #(
		.MAX_SENSORS (MAX_SENSORS),
		.STAT_WIDTH  (STAT_WIDTH)
	) u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.q_empty              (q_empty),
		.cmd                  (back_item),
		.pop                  (q_pop),
		.limit                (limit),
		.debounce_needed      (debounce_needed_q),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.event_kind           (event_kind),
		.event_sensor         (event_sensor),
		.event_distance_q4    (event_distance_q4),
		.stop_motors          (stop_motors),
		.run_mode             (run_mode),
		.poll_count           (poll_count),
		.obstacle_count       (obstacle_count),
		.false_positive_total (false_positive_total)
	);

endmodule

// ===== design/msod_checker.sv =====
// ----------------------------------------------------------------------------
// msod_checker
// Port-level checks of the obstacle debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module msod_checker #(
	parameter int STAT_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    event_kind,
	input logic [msod_pkg::IDX_W-1:0]    event_sensor,
	input logic [msod_pkg::DIST_W-1:0]   event_distance_q4,
	input logic                          stop_motors,
	input logic [1:0]                    run_mode,
	input logic [STAT_WIDTH-1:0]         poll_count
);

	// a stop pulse only comes with the move into obstacle mode
	a_stop_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stop_motors |-> run_mode == msod_pkg::MODE_OBSTACLE)
		else $error("stop_motors without obstacle mode");

	// no edge: sensor and distance read zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == msod_pkg::EV_NONE |->
		event_sensor == '0 && event_distance_q4 == '0)
		else $error("edge fields set without an edge");

	// detect edges never come while stopped
	a_detect_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == msod_pkg::EV_DETECT |->
		run_mode != msod_pkg::MODE_STOPPED)
		else $error("detect edge while stopped");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) &&
		$stable(run_mode) && $stable(poll_count))
		else $error("stalled result beat changed");

endmodule

bind multi_sensor_obstacle_debouncer msod_checker #(
	.STAT_WIDTH (STAT_WIDTH)
) u_msod_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.event_kind        (event_kind),
	.event_sensor      (event_sensor),
	.event_distance_q4 (event_distance_q4),
	.stop_motors       (stop_motors),
	.run_mode          (run_mode),
	.poll_count        (poll_count)
);
